// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL file that checks itself (the scorer top level).
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/cas_pkg.sv =====
// Package for the CIGAR alignment scorer: operation and register codes,
// fixed-point constants and a saturating add. Depends on nothing.
`default_nettype none

package cas_pkg;

    typedef enum logic [1:0] {
        OP_MATCH  = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_OTHER  = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        CFG_MAX_MISMATCH_RATE  = 2'd0,
        CFG_MAX_INDEL_RATE     = 2'd1,
        CFG_MAX_MISMATCH_TOTAL = 2'd2,
        CFG_MAX_INDEL_TOTAL    = 2'd3
    } cfg_idx_t;

    localparam int RATE_W      = 17;
    localparam int Q_FRAC_BITS = 16;
    localparam logic [RATE_W-1:0] ONE_Q16 = 17'h10000;
    localparam int TOTAL_W     = 32;
    localparam int OUT_W       = 32;
    localparam int MAX_SUM_W   = 48;

    // Saturating add at the widest sum width; callers pass their own ceiling.
    function automatic logic [MAX_SUM_W-1:0] sat_add(
        input logic [MAX_SUM_W-1:0] a,
        input logic [MAX_SUM_W-1:0] b,
        input logic [MAX_SUM_W-1:0] ceiling
    );
        logic [MAX_SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ceiling}) ? ceiling : s[MAX_SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cas_ifs.sv =====
// Channel interfaces of the CIGAR alignment scorer: operation input,
// result output and configuration write. Depends on nothing.
`default_nettype none

interface cas_op_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op_kind;
    logic [15:0] run_length;
    logic        last_op;

    modport source (output valid, op_kind, run_length, last_op, input ready);
    modport sink   (input valid, op_kind, run_length, last_op, output ready);
endinterface

interface cas_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] mismatch_sum;
    logic [31:0] indel_sum;
    logic [31:0] aligned_length;
    logic        rate_ok;
    logic        count_ok;

    modport source (output valid, mismatch_sum, indel_sum, aligned_length,
                    rate_ok, count_ok, input ready);
    modport sink   (input valid, mismatch_sum, indel_sum, aligned_length,
                    rate_ok, count_ok, output ready);
endinterface

interface cas_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/cas_run_tracker.sv =====
// Run tracker: merges adjacent operations, closes runs into the sums and
// hands the closed sums and the trailing run off on the last operation.
// Depends on cas_pkg.
`default_nettype none

module cas_run_tracker #(
    parameter int SUM_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire cas_pkg::op_kind_t     kind,
    input  wire logic [SUM_BITS-1:0]   len,
    input  wire logic                  last,
    output cas_pkg::op_kind_t          trail_kind,
    output logic [SUM_BITS-1:0]        trail_len,
    output logic [SUM_BITS-1:0]        closed_mism,
    output logic [SUM_BITS-1:0]        closed_indel,
    output logic [SUM_BITS-1:0]        closed_len
);

    localparam logic [cas_pkg::MAX_SUM_W-1:0] SUM_MAX =
        (48'd1 << SUM_BITS) - 48'd1;

    cas_pkg::op_kind_t     pend_kind_reg, pend_kind_next;
    logic [SUM_BITS-1:0]   pend_len_reg, pend_len_next;
    logic                  open_reg, open_next;
    logic                  lead_reg, lead_next;
    logic [SUM_BITS-1:0]   mism_reg, mism_next;
    logic [SUM_BITS-1:0]   indel_reg, indel_next;
    logic [SUM_BITS-1:0]   len_acc_reg, len_acc_next;

    logic                  merge;
    logic                  close;
    logic                  pend_indel;
    logic [SUM_BITS-1:0]   run_len;

    always_comb
    begin
        merge      = open_reg && (pend_kind_reg == kind);
        close      = open_reg && !merge;
        pend_indel = (pend_kind_reg == cas_pkg::OP_INSERT) ||
                     (pend_kind_reg == cas_pkg::OP_DELETE);

        closed_mism  = mism_reg;
        closed_indel = indel_reg;
        closed_len   = len_acc_reg;
        if (close)
        begin
            if (pend_kind_reg == cas_pkg::OP_OTHER)
                closed_mism = SUM_BITS'(cas_pkg::sat_add(48'(mism_reg),
                                                         48'(pend_len_reg), SUM_MAX));
            if (pend_indel && !lead_reg)
                closed_indel = SUM_BITS'(cas_pkg::sat_add(48'(indel_reg),
                                                          48'(pend_len_reg), SUM_MAX));
            if (!(pend_indel && lead_reg))
                closed_len = SUM_BITS'(cas_pkg::sat_add(48'(len_acc_reg),
                                                        48'(pend_len_reg), SUM_MAX));
        end

        run_len = merge ? SUM_BITS'(cas_pkg::sat_add(48'(pend_len_reg), 48'(len), SUM_MAX))
                        : len;
        trail_kind = kind;
        trail_len  = run_len;

        pend_kind_next = pend_kind_reg;
        pend_len_next  = pend_len_reg;
        open_next      = open_reg;
        lead_next      = lead_reg;
        mism_next      = mism_reg;
        indel_next     = indel_reg;
        len_acc_next   = len_acc_reg;
        if (step)
        begin
            if (last)
            begin
                // clear for the next alignment
                pend_kind_next = cas_pkg::OP_MATCH;
                pend_len_next  = '0;
                open_next      = 1'b0;
                lead_next      = 1'b1;
                mism_next      = '0;
                indel_next     = '0;
                len_acc_next   = '0;
            end
            else
            begin
                pend_kind_next = kind;
                pend_len_next  = run_len;
                open_next      = 1'b1;
                lead_next      = close ? 1'b0 : lead_reg;
                mism_next      = closed_mism;
                indel_next     = closed_indel;
                len_acc_next   = closed_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_kind_reg <= cas_pkg::OP_MATCH;
            pend_len_reg  <= '0;
            open_reg      <= 1'b0;
            lead_reg      <= 1'b1;
            mism_reg      <= '0;
            indel_reg     <= '0;
            len_acc_reg   <= '0;
        end
        else
        begin
            pend_kind_reg <= pend_kind_next;
            pend_len_reg  <= pend_len_next;
            open_reg      <= open_next;
            lead_reg      <= lead_next;
            mism_reg      <= mism_next;
            indel_reg     <= indel_next;
            len_acc_reg   <= len_acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cas_flag_pipe.sv =====
// Flag pipeline: registers the final sums, forms the rate products and the
// count check, then compares and holds the result for the output channel.
// Depends on cas_pkg and cas_ifs.
`default_nettype none

module cas_flag_pipe #(
    parameter int SUM_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [SUM_BITS-1:0]            mism,
    input  wire logic [SUM_BITS-1:0]            indel,
    input  wire logic [SUM_BITS-1:0]            len,
    input  wire logic [cas_pkg::RATE_W-1:0]     mism_rate,
    input  wire logic [cas_pkg::RATE_W-1:0]     indel_rate,
    input  wire logic [cas_pkg::TOTAL_W-1:0]    mism_total,
    input  wire logic [cas_pkg::TOTAL_W-1:0]    indel_total,
    cas_res_if.source                           res
);

    localparam int PROD_W = SUM_BITS + cas_pkg::RATE_W;
    localparam int CMP_W  = (SUM_BITS > cas_pkg::OUT_W) ? SUM_BITS : cas_pkg::OUT_W;

    // stage 1: final sums
    logic                 p1_valid_reg;
    logic [SUM_BITS-1:0]  p1_mism_reg, p1_indel_reg, p1_len_reg;
    // stage 2: products and count check
    logic                 p2_valid_reg;
    logic [SUM_BITS-1:0]  p2_mism_reg, p2_indel_reg, p2_len_reg;
    logic [PROD_W-1:0]    p2_mprod_reg, p2_iprod_reg;
    logic                 p2_count_ok_reg, p2_nonzero_reg;
    // result register
    logic                 out_valid_reg;
    logic [cas_pkg::OUT_W-1:0] out_mism_reg, out_indel_reg, out_len_reg;
    logic                 out_rate_ok_reg, out_count_ok_reg;

    logic                 out_ready_int, p2_ready, p1_ready;
    logic [cas_pkg::RATE_W-1:0] mrate_c, irate_c;
    logic [PROD_W-1:0]    mprod_next, iprod_next;
    logic                 count_ok_next, rate_ok_next;
    logic [CMP_W-1:0]     mism_w, indel_w, len_w;

    assign out_ready_int = !out_valid_reg || res.ready;
    assign p2_ready      = !p2_valid_reg || out_ready_int;
    assign p1_ready      = !p1_valid_reg || p2_ready;
    assign in_ready      = p1_ready;

    always_comb
    begin
        // rates above one act as one
        mrate_c = (mism_rate > cas_pkg::ONE_Q16) ? cas_pkg::ONE_Q16 : mism_rate;
        irate_c = (indel_rate > cas_pkg::ONE_Q16) ? cas_pkg::ONE_Q16 : indel_rate;
        mprod_next = PROD_W'(mrate_c) * PROD_W'(p1_len_reg);
        iprod_next = PROD_W'(irate_c) * PROD_W'(p1_len_reg);
        count_ok_next = (CMP_W'(p1_mism_reg) <= CMP_W'(mism_total)) &&
                        (CMP_W'(p1_indel_reg) <= CMP_W'(indel_total));

        rate_ok_next = p2_nonzero_reg &&
            ((PROD_W'(p2_mism_reg) << cas_pkg::Q_FRAC_BITS) <= p2_mprod_reg) &&
            ((PROD_W'(p2_indel_reg) << cas_pkg::Q_FRAC_BITS) <= p2_iprod_reg);
        mism_w  = CMP_W'(p2_mism_reg);
        indel_w = CMP_W'(p2_indel_reg);
        len_w   = CMP_W'(p2_len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_ready)
                p1_valid_reg <= in_valid;
            if (p2_ready)
                p2_valid_reg <= p1_valid_reg;
            if (out_ready_int)
                out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready && in_valid)
        begin
            p1_mism_reg  <= mism;
            p1_indel_reg <= indel;
            p1_len_reg   <= len;
        end
        if (p2_ready && p1_valid_reg)
        begin
            p2_mism_reg     <= p1_mism_reg;
            p2_indel_reg    <= p1_indel_reg;
            p2_len_reg      <= p1_len_reg;
            p2_mprod_reg    <= mprod_next;
            p2_iprod_reg    <= iprod_next;
            p2_count_ok_reg <= count_ok_next;
            p2_nonzero_reg  <= (p1_len_reg != '0);
        end
        if (out_ready_int && p2_valid_reg)
        begin
            out_mism_reg     <= mism_w[cas_pkg::OUT_W-1:0];
            out_indel_reg    <= indel_w[cas_pkg::OUT_W-1:0];
            out_len_reg      <= len_w[cas_pkg::OUT_W-1:0];
            out_rate_ok_reg  <= rate_ok_next;
            out_count_ok_reg <= p2_count_ok_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.mismatch_sum   = out_mism_reg;
    assign res.indel_sum      = out_indel_reg;
    assign res.aligned_length = out_len_reg;
    assign res.rate_ok        = out_rate_ok_reg;
    assign res.count_ok       = out_count_ok_reg;

endmodule

`default_nettype wire

// ===== hdl/cigar_alignment_scorer_top.sv =====
// Top level of the CIGAR alignment scorer: input register, run tracker,
// hand-off register, flag pipeline and configuration registers.
// Depends on cas_pkg, cas_ifs, cas_run_tracker, cas_flag_pipe, assert_macros.svh.
//
// Usage:
//   op  : one CIGAR operation per transfer (kind, run length, last flag).
//   res : one result per alignment, sent after the transfer of its last op.
//   cfg : register writes (index 0..3), always ready; write only while idle.
// Throughput is one operation per cycle unless a stall reaches the hand-off register:
// each op only touches the held run and the running sums, so no stage holds it back.
// A last op, once transferred, passes the input register, the run tracker into the
// hand-off register, the final sums, the products and the compare into the result
// register before res.valid rises.
// Reset clears the run state (no run held, next run leading, sums zero) and
// sets the rate limits to one and the count limits to all ones.
// When res stalls, the result register holds and each stage behind it fills
// in turn; ops that are not last still stream into the tracker until a last
// op finds the hand-off register full, then op.ready drops.
`default_nettype none
`include "assert_macros.svh"

module cigar_alignment_scorer_top #(
    parameter int RUN_BITS = 16,
    parameter int SUM_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cas_op_if.sink    op,
    cas_cfg_if.sink   cfg,
    cas_res_if.source res
);

    // Mask applied to the 16-bit run length field.
    localparam logic [15:0] RUN_MASK =
        (RUN_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << RUN_BITS) - 32'd1);
    localparam logic [cas_pkg::MAX_SUM_W-1:0] SUM_MAX =
        (48'd1 << SUM_BITS) - 48'd1;

    // Configuration registers.
    logic [cas_pkg::RATE_W-1:0]  mrate_reg, irate_reg;
    logic [cas_pkg::TOTAL_W-1:0] mtotal_reg, itotal_reg;

    // Input register.
    logic                 s1_valid_reg;
    cas_pkg::op_kind_t    s1_kind_reg;
    logic [SUM_BITS-1:0]  s1_len_reg;
    logic                 s1_last_reg;

    // Hand-off register: sums with inner runs closed, plus the trailing run.
    logic                 s2_valid_reg;
    logic [SUM_BITS-1:0]  s2_mism_reg, s2_indel_reg, s2_len_reg;
    cas_pkg::op_kind_t    s2_tkind_reg;
    logic [SUM_BITS-1:0]  s2_tlen_reg;

    logic                 s1_move, s2_ready, pipe_ready, op_xfer;
    cas_pkg::op_kind_t    trail_kind;
    logic [SUM_BITS-1:0]  trail_len, closed_mism, closed_indel, closed_len;
    logic [SUM_BITS-1:0]  fin_mism, fin_indel, fin_len;

    // Handshake: non-last ops always drain; a last op needs the hand-off slot.
    assign s2_ready = !s2_valid_reg || pipe_ready;
    assign s1_move  = s1_valid_reg && (!s1_last_reg || s2_ready);
    assign op.ready = !s1_valid_reg || s1_move;
    assign op_xfer  = op.valid && op.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mrate_reg  <= cas_pkg::ONE_Q16;
            irate_reg  <= cas_pkg::ONE_Q16;
            mtotal_reg <= '1;
            itotal_reg <= '1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cas_pkg::cfg_idx_t'(cfg.index))
                cas_pkg::CFG_MAX_MISMATCH_RATE:  mrate_reg  <= cfg.data[cas_pkg::RATE_W-1:0];
                cas_pkg::CFG_MAX_INDEL_RATE:     irate_reg  <= cfg.data[cas_pkg::RATE_W-1:0];
                cas_pkg::CFG_MAX_MISMATCH_TOTAL: mtotal_reg <= cfg.data;
                cas_pkg::CFG_MAX_INDEL_TOTAL:    itotal_reg <= cfg.data;
            endcase
        end
    end

    // Valid bits of the input and hand-off registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (op.ready)
                s1_valid_reg <= op.valid;
            if (s2_ready)
                s2_valid_reg <= s1_move && s1_last_reg;
        end
    end

    // Payload: capture the op with its run length masked to RUN_BITS.
    always_ff @(posedge clk)
    begin
        if (op_xfer)
        begin
            s1_kind_reg <= cas_pkg::op_kind_t'(op.op_kind);
            s1_len_reg  <= SUM_BITS'(op.run_length & RUN_MASK);
            s1_last_reg <= op.last_op;
        end
        if (s2_ready && s1_move && s1_last_reg)
        begin
            s2_mism_reg  <= closed_mism;
            s2_indel_reg <= closed_indel;
            s2_len_reg   <= closed_len;
            s2_tkind_reg <= trail_kind;
            s2_tlen_reg  <= trail_len;
        end
    end

    cas_run_tracker #(
        .SUM_BITS (SUM_BITS)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_move),
        .kind         (s1_kind_reg),
        .len          (s1_len_reg),
        .last         (s1_last_reg),
        .trail_kind   (trail_kind),
        .trail_len    (trail_len),
        .closed_mism  (closed_mism),
        .closed_indel (closed_indel),
        .closed_len   (closed_len)
    );

    // Trailing run sits at the edge: drop indels, count matches and others.
    always_comb
    begin
        fin_mism  = s2_mism_reg;
        fin_indel = s2_indel_reg;
        fin_len   = s2_len_reg;
        unique case (s2_tkind_reg)
            cas_pkg::OP_MATCH:
                fin_len = SUM_BITS'(cas_pkg::sat_add(48'(s2_len_reg), 48'(s2_tlen_reg), SUM_MAX));
            cas_pkg::OP_OTHER:
            begin
                fin_mism = SUM_BITS'(cas_pkg::sat_add(48'(s2_mism_reg), 48'(s2_tlen_reg),
                                                      SUM_MAX));
                fin_len  = SUM_BITS'(cas_pkg::sat_add(48'(s2_len_reg), 48'(s2_tlen_reg),
                                                      SUM_MAX));
            end
            cas_pkg::OP_INSERT, cas_pkg::OP_DELETE:
                fin_len = s2_len_reg;
        endcase
    end

    cas_flag_pipe #(
        .SUM_BITS (SUM_BITS)
    ) u_flags (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s2_valid_reg),
        .in_ready    (pipe_ready),
        .mism        (fin_mism),
        .indel       (fin_indel),
        .len         (fin_len),
        .mism_rate   (mrate_reg),
        .indel_rate  (irate_reg),
        .mism_total  (mtotal_reg),
        .indel_total (itotal_reg),
        .res         (res)
    );

    // A held op that does not end its alignment never stalls.
    `ASSERT_IMPLIES(a_inner_op_drains, clk, rst_n, s1_valid_reg && !s1_last_reg, s1_move)
    // A last op leaving the input register lands in the hand-off register.
    `ASSERT_NEXT(a_last_op_handoff, clk, rst_n, s1_move && s1_last_reg, s2_valid_reg)
    // A stalled hand-off holds its sums.
    `ASSERT_NEXT(a_handoff_holds, clk, rst_n, s2_valid_reg && !pipe_ready,
                 s2_valid_reg && $stable(s2_len_reg) && $stable(s2_tlen_reg))

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cigar_alignment_scorer_top: streams CIGAR operations,
// predicts per-alignment sums and pass flags, and compares every result.
// Depends on cas_pkg, cas_ifs and the scorer RTL.

module testbench;

    import cas_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          SETTLE_TICKS = 8;
    localparam int          IDLE_PCT     = 14;
    localparam int          PHASE_OPS    = 275;
    localparam int          HOLD_TICKS   = 400;
    localparam logic [63:0] SUM_CEIL     = (64'd1 << 32) - 64'd1;

    // One scored alignment as it leaves the block.
    typedef struct {
        logic [31:0] mismatch_sum;
        logic [31:0] indel_sum;
        logic [31:0] aligned_length;
        logic        rate_ok;
        logic        count_ok;
    } score_t;

    // Tracks the run state and limits of the scorer and keeps the scores
    // that accepted operations have caused but the block has not yet sent.
    class alignment_scoreboard;
        logic [63:0] mismatch_rate_lim;
        logic [63:0] indel_rate_lim;
        logic [63:0] mismatch_total_lim;
        logic [63:0] indel_total_lim;
        op_kind_t    held_kind;
        logic [63:0] held_len;
        bit          run_open;
        bit          run_leading;
        logic [63:0] mismatch_acc;
        logic [63:0] indel_acc;
        logic [63:0] length_acc;
        score_t      expected_scores[$];
        int          errors;
        int          checked;

        function new();
            mismatch_rate_lim  = {47'd0, ONE_Q16};
            indel_rate_lim     = {47'd0, ONE_Q16};
            mismatch_total_lim = SUM_CEIL;
            indel_total_lim    = SUM_CEIL;
            errors  = 0;
            checked = 0;
            clear_alignment();
        endfunction

        function void clear_alignment();
            held_kind    = OP_MATCH;
            held_len     = 64'd0;
            run_open     = 1'b0;
            run_leading  = 1'b1;
            mismatch_acc = 64'd0;
            indel_acc    = 64'd0;
            length_acc   = 64'd0;
        endfunction

        function logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            return (s > SUM_CEIL) ? SUM_CEIL : s;
        endfunction

        // Edge insertion and deletion runs are dropped entirely.
        function void close_run(op_kind_t kind, logic [63:0] len, bit at_edge);
            if (kind == OP_INSERT || kind == OP_DELETE) begin
                if (at_edge)
                    return;
                indel_acc = clamp_add(indel_acc, len);
            end
            else if (kind == OP_OTHER) begin
                mismatch_acc = clamp_add(mismatch_acc, len);
            end
            length_acc = clamp_add(length_acc, len);
        endfunction

        function bit rate_within(logic [63:0] sum, logic [63:0] rate, logic [63:0] len);
            logic [63:0] r;
            r = (rate > {47'd0, ONE_Q16}) ? {47'd0, ONE_Q16} : rate;
            return (sum << Q_FRAC_BITS) <= r * len;
        endfunction

        function void set_limit(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_MAX_MISMATCH_RATE:  mismatch_rate_lim  = {47'd0, value[RATE_W-1:0]};
                CFG_MAX_INDEL_RATE:     indel_rate_lim     = {47'd0, value[RATE_W-1:0]};
                CFG_MAX_MISMATCH_TOTAL: mismatch_total_lim = {32'd0, value};
                CFG_MAX_INDEL_TOTAL:    indel_total_lim    = {32'd0, value};
                default: ;
            endcase
        endfunction

        function void note_op(op_kind_t kind, logic [15:0] len, logic last);
            score_t      s;
            logic [63:0] run;
            run = {48'd0, len};
            if (run_open && held_kind == kind) begin
                held_len = clamp_add(held_len, run);
            end
            else begin
                if (run_open) begin
                    close_run(held_kind, held_len, run_leading);
                    run_leading = 1'b0;
                end
                held_kind = kind;
                held_len  = run;
                run_open  = 1'b1;
            end
            if (!last)
                return;
            close_run(held_kind, held_len, 1'b1);
            s.mismatch_sum   = mismatch_acc[31:0];
            s.indel_sum      = indel_acc[31:0];
            s.aligned_length = length_acc[31:0];
            s.rate_ok  = (length_acc != 64'd0) &&
                         rate_within(mismatch_acc, mismatch_rate_lim, length_acc) &&
                         rate_within(indel_acc, indel_rate_lim, length_acc);
            s.count_ok = (mismatch_acc <= mismatch_total_lim) &&
                         (indel_acc <= indel_total_lim);
            expected_scores.insert(expected_scores.size(), s);
            clear_alignment();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(score_t got);
            score_t want;
            checked++;
            if (expected_scores.size() == 0) begin
                $error("result with no alignment outstanding: mismatch %0d indel %0d len %0d",
                       got.mismatch_sum, got.indel_sum, got.aligned_length);
                errors++;
                return;
            end
            want = expected_scores.pop_front();
            compare_field("mismatch_sum", want.mismatch_sum, got.mismatch_sum);
            compare_field("indel_sum", want.indel_sum, got.indel_sum);
            compare_field("aligned_length", want.aligned_length, got.aligned_length);
            compare_field("rate_ok", {31'd0, want.rate_ok}, {31'd0, got.rate_ok});
            compare_field("count_ok", {31'd0, want.count_ok}, {31'd0, got.count_ok});
        endfunction

        function int outstanding();
            return expected_scores.size();
        endfunction
    endclass

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int          ops_sent    = 0;
    int          limit_sets  = 0;

    alignment_scoreboard sb = new();

    cas_op_if  op_ch();
    cas_cfg_if cfg_ch();
    cas_res_if res_ch();

    cigar_alignment_scorer_top #(
        .RUN_BITS (16),
        .SUM_BITS (32)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch),
        .cfg   (cfg_ch),
        .res   (res_ch)
    );

    // 12 ns clock.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: fail the run if it is still going when cycle_count reaches CYCLE_LIMIT.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offer one operation, optionally after a few idle cycles, and hold it
    // until the transfer. Valid stays high on return so back-to-back
    // operations keep the channel busy; callers that stop must drop it.
    task automatic send_op(input op_kind_t kind, input logic [15:0] len, input logic last);
        bit quiet;
        quiet = (ops_sent >= 400 && ops_sent < 800);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            op_ch.valid <= 1'b0;
            @(posedge clk);
        end
        op_ch.valid      <= 1'b1;
        op_ch.op_kind    <= kind;
        op_ch.run_length <= len;
        op_ch.last_op    <= last;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        sb.note_op(kind, len, last);
        ops_sent++;
    endtask

    // Drop valid, wait for every outstanding score, then give the pipeline
    // a few more cycles so no operation is still in flight.
    task automatic settle();
        op_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write one limit register; valid is left high for a following write.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_limit(idx, value);
    endtask

    task automatic program_limits(input logic [31:0] mm_rate, input logic [31:0] id_rate,
                                  input logic [31:0] mm_total, input logic [31:0] id_total);
        write_reg(CFG_MAX_MISMATCH_RATE, mm_rate);
        write_reg(CFG_MAX_INDEL_RATE, id_rate);
        write_reg(CFG_MAX_MISMATCH_TOTAL, mm_total);
        write_reg(CFG_MAX_INDEL_TOTAL, id_total);
        cfg_ch.valid <= 1'b0;
        limit_sets++;
    endtask

    // One alignment of random content. Repeats of the previous kind are
    // favored so merged runs are common; run lengths are mostly short with
    // zero, full-scale and full-range values mixed in.
    task automatic send_alignment(input int n_ops);
        op_kind_t    kind;
        op_kind_t    prev;
        logic [15:0] len;
        int          r;
        prev = OP_MATCH;
        for (int i = 0; i < n_ops; i++)
        begin
            r = $urandom_range(0, 99);
            if (i > 0 && r < 30)
                kind = prev;
            else
            begin
                r = $urandom_range(0, 99);
                kind = (r < 45) ? OP_MATCH : (r < 60) ? OP_INSERT :
                       (r < 75) ? OP_DELETE : OP_OTHER;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                len = 16'd0;
            else if (r < 10)
                len = 16'hFFFF;
            else if (r < 20)
                len = 16'($urandom());
            else
                len = 16'($urandom_range(1, 150));
            send_op(kind, len, i == n_ops - 1);
            prev = kind;
        end
    endtask

    // Result side: check every transfer, toggle ready at random but keep it high in a quiet
    // window, and once hold ready low for a long stretch so the block backs up into its input.
    initial
    begin : result_sink
        int     hold_left;
        bit     held_once;
        bit     quiet;
        score_t got;
        hold_left = 0;
        held_once = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.mismatch_sum   = res_ch.mismatch_sum;
                got.indel_sum      = res_ch.indel_sum;
                got.aligned_length = res_ch.aligned_length;
                got.rate_ok        = res_ch.rate_ok;
                got.count_ok       = res_ch.count_ok;
                sb.check_result(got);
            end
            if (!held_once && sb.checked == 40)
            begin
                held_once = 1'b1;
                hold_left = HOLD_TICKS;
            end
            quiet = (sb.checked >= 100 && sb.checked < 160);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (quiet)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus: directed records, then random phases under several limit
    // settings.
    initial
    begin : stimulus
        int phase_ops;
        int n_ops;
        int records;
        op_ch.valid      <= 1'b0;
        op_ch.op_kind    <= OP_MATCH;
        op_ch.run_length <= 16'd0;
        op_ch.last_op    <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_MAX_MISMATCH_RATE;
        cfg_ch.data      <= 32'd0;

        // Hold reset from time zero, then release it once.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset limits, written explicitly.
        program_limits({15'd0, ONE_Q16}, {15'd0, ONE_Q16}, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // A lone zero-length match: length zero fails the rate flag.
        send_op(OP_MATCH, 16'd0, 1'b1);
        // A lone insertion is both leading and trailing: all sums zero.
        send_op(OP_INSERT, 16'd5, 1'b1);
        // Edge indels dropped, inner deletion counted, full-scale match.
        send_op(OP_INSERT, 16'd3, 1'b0);
        send_op(OP_MATCH, 16'd10, 1'b0);
        send_op(OP_OTHER, 16'd2, 1'b0);
        send_op(OP_DELETE, 16'd4, 1'b0);
        send_op(OP_MATCH, 16'hFFFF, 1'b0);
        send_op(OP_DELETE, 16'd7, 1'b1);
        // Merging of equal kinds, and a zero-length inner insertion.
        send_op(OP_MATCH, 16'd100, 1'b0);
        send_op(OP_MATCH, 16'd200, 1'b0);
        send_op(OP_OTHER, 16'hFFFF, 1'b0);
        send_op(OP_OTHER, 16'hFFFF, 1'b0);
        send_op(OP_INSERT, 16'd0, 1'b0);
        send_op(OP_MATCH, 16'd1, 1'b1);
        // Zero-length runs as leading and trailing edges.
        send_op(OP_DELETE, 16'd0, 1'b0);
        send_op(OP_MATCH, 16'd0, 1'b0);
        send_op(OP_INSERT, 16'd0, 1'b1);
        // Mismatch fraction of exactly one.
        send_op(OP_OTHER, 16'hFFFF, 1'b1);
        settle();

        // Random phases; the first two use the extreme settings, the third a fixed mixed one.
        for (int phase = 1; phase <= 6; phase++)
        begin
            case (phase)
                1: program_limits(32'd0, 32'd0, 32'd0, 32'd0);
                2: program_limits(32'h1FFFF, 32'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: program_limits({15'd0, ONE_Q16}, 32'h4000, 32'd100000, 32'd50000);
                default: program_limits($urandom_range(0, 32'h8000), $urandom_range(0, 32'h8000),
                                        $urandom_range(0, 400000), $urandom_range(0, 400000));
            endcase
            phase_ops = 0;
            records   = 0;
            while (phase_ops < PHASE_OPS)
            begin
                // Mostly multi-operation records, some single-operation ones.
                n_ops = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
                send_alignment(n_ops);
                phase_ops += n_ops;
                records++;
                // Pause the sender once until every score has come back.
                if (phase == 3 && records == 20)
                    settle();
            end
            settle();
        end

        if (sb.outstanding() != 0)
        begin
            $error("%0d scores never arrived", sb.outstanding());
            sb.errors++;
        end
        $display("Scored %0d alignments from %0d operations over %0d sets of limits,",
                 sb.checked, ops_sent, limit_sets);
        $display("with edge indels, merged runs, zero lengths and long output stalls.");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cas_pkg.sv
hdl/cas_ifs.sv
hdl/cas_run_tracker.sv
hdl/cas_flag_pipe.sv
hdl/cigar_alignment_scorer_top.sv
tb/sv/testbench.sv
